// ===== hdl/ssc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, codes and helpers for the servo slew and calibration block.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int NUM_SERVOS  = 3;
  localparam int SHOWN       = (NUM_SERVOS < 3) ? NUM_SERVOS : 3;
  localparam int CH_W        = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int POS_W       = 10;
  localparam int WID_W       = 12;

  localparam logic [POS_W-1:0] MID_POS      = 10'd512;
  localparam logic [7:0]       SLEW_DIV_RST = 8'd4;
  localparam logic [7:0]       PULSE_DIV_RST = 8'd10;
  localparam logic [1:0]       ADC_NONE     = 2'd3;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_BUTTON  = 3'd1,
    MODE_COMMAND = 3'd2,
    MODE_ADC     = 3'd3,
    MODE_RESTORE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    PH_RUN   = 2'd0,
    PH_START = 2'd1,
    PH_END   = 2'd2
  } phase_t;

  // command: open / close; restore: start / end / last position
  localparam logic [1:0] CH_OPEN  = 2'd0;
  localparam logic [1:0] CH_CLOSE = 2'd1;
  localparam logic [1:0] CH_START = 2'd0;
  localparam logic [1:0] CH_END   = 2'd1;
  localparam logic [1:0] CH_LAST  = 2'd2;

  // register map, word index
  localparam logic [1:0] REG_SLEW_DIV  = 2'd0;
  localparam logic [1:0] REG_PULSE_DIV = 2'd1;
  localparam logic [1:0] REG_ALWAYS    = 2'd2;

  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_RED   = 2'd1;
  localparam logic [1:0] LED_GRN   = 2'd2;

  // 600 us + pos * 2.34375 us
  function automatic logic [WID_W-1:0] pulse_width(input logic [POS_W-1:0] pos);
    logic [16:0] prod;
    prod = {7'd0, pos} * 17'd75;
    return WID_W'(prod >> 5) + 12'd600;
  endfunction

endpackage

// ===== hdl/servo_slew_calibration_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_slew_calibration_controller
// Slew-limited positioning of the servos, pulse frame timing and the
// button driven calibration sequence, one event per beat.
// ----------------------------------------------------------------------------
// An accepted event is held in the input register and moves on to the
//   result register once the output can advance.
// Throughput: one event per cycle while the output is not stalled; the
//   empty input register takes a beat while a finished result still waits.
// Reset (rst_n low, synchronous): registers back to defaults, positions and
//   targets to mid travel; no clearing pass, ready in the first cycle after.
module servo_slew_calibration_controller
  import ssc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // event channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_mode,
  input  logic [1:0]            in_servo,
  input  logic [1:0]            in_choice,
  input  logic [15:0]           in_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_pulse_mask,
  output logic [POS_W-1:0]      out_position_a,
  output logic [POS_W-1:0]      out_position_b,
  output logic [POS_W-1:0]      out_position_c,
  output logic [WID_W-1:0]      out_width_a,
  output logic [WID_W-1:0]      out_width_b,
  output logic [WID_W-1:0]      out_width_c,
  output logic [2:0]            out_save_position_mask,
  output logic                  out_save_calibration,
  output logic [1:0]            out_cal_phase,
  output logic [1:0]            out_led_state,
  output logic [1:0]            out_adc_request,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration registers
  logic [7:0] slew_div_r, pulse_div_r;
  logic       always_r;

  // input stage
  logic        s1_v_r;
  logic [2:0]  mode_r;
  logic [1:0]  servo_r, choice_r;
  logic [15:0] value_r;

  // servo state
  logic [POS_W-1:0] pos_r   [NUM_SERVOS];
  logic [POS_W-1:0] tgt_r   [NUM_SERVOS];
  logic [POS_W-1:0] start_r [NUM_SERVOS];
  logic [POS_W-1:0] end_r   [NUM_SERVOS];
  logic [POS_W-1:0] pos_nxt   [NUM_SERVOS];
  logic [POS_W-1:0] tgt_nxt   [NUM_SERVOS];
  logic [POS_W-1:0] start_nxt [NUM_SERVOS];
  logic [POS_W-1:0] end_nxt   [NUM_SERVOS];
  logic [NUM_SERVOS-1:0] arr_r, arr_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] slew_cnt_r, slew_cnt_nxt, frame_cnt_r, frame_cnt_nxt;
  logic [CH_W-1:0] adc_ch_r, adc_ch_nxt;

  logic [7:0] slew_dec, frame_dec;
  logic [NUM_SERVOS-1:0] pulse_vec, save_vec;
  logic       save_cal;
  logic [1:0] adc_req, led_nxt;
  logic [2:0] pulse_show, save_show;
  logic [POS_W-1:0] show_pos [3];
  logic [POS_W-1:0] sample, last_pos;

  // result registers
  logic             out_valid_r;
  logic [2:0]       pulse_mask_r, save_mask_r;
  logic [POS_W-1:0] posa_r, posb_r, posc_r;
  logic [WID_W-1:0] wida_r, widb_r, widc_r;
  logic             save_cal_r;
  logic [1:0]       cal_phase_r, led_r, adc_req_r;

  logic cfg_wr, advance, fire;

  // --------------------------------------------------------------------------
  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_div_r  <= SLEW_DIV_RST;
      pulse_div_r <= PULSE_DIV_RST;
      always_r    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SLEW_DIV:  slew_div_r  <= pwdata[7:0];
        REG_PULSE_DIV: pulse_div_r <= pwdata[7:0];
        REG_ALWAYS:    always_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SLEW_DIV:  prdata = {24'd0, slew_div_r};
      REG_PULSE_DIV: prdata = {24'd0, pulse_div_r};
      REG_ALWAYS:    prdata = {31'd0, always_r};
      default:       prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // handshake: input register parts the channels
  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_v_r && advance;
  assign in_ready = !s1_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= in_mode;
      servo_r  <= in_servo;
      choice_r <= in_choice;
      value_r  <= in_value;
    end
  end

  // --------------------------------------------------------------------------
  // event processing
  assign slew_dec  = slew_cnt_r - 8'd1;
  assign frame_dec = frame_cnt_r - 8'd1;
  assign sample    = value_r[POS_W-1:0];
  assign last_pos  = (value_r != 16'd0 && value_r < 16'd1024) ? value_r[POS_W-1:0] : MID_POS;

  always_comb begin
    pos_nxt       = pos_r;
    tgt_nxt       = tgt_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    arr_nxt       = arr_r;
    phase_nxt     = phase_r;
    slew_cnt_nxt  = slew_cnt_r;
    frame_cnt_nxt = frame_cnt_r;
    adc_ch_nxt    = adc_ch_r;
    pulse_vec     = '0;
    save_vec      = '0;
    save_cal      = 1'b0;
    adc_req       = ADC_NONE;
    if (fire) begin
      case (mode_t'(mode_r))
        MODE_TICK: begin
          if (phase_r == PH_RUN) begin
            slew_cnt_nxt = slew_dec;
            if (slew_dec == 8'd0) begin
              for (int i = 0; i < NUM_SERVOS; i++) begin
                if (pos_r[i] > tgt_r[i]) begin
                  pos_nxt[i] = pos_r[i] - 1'b1;
                  arr_nxt[i] = 1'b0;
                end else if (pos_r[i] < tgt_r[i]) begin
                  pos_nxt[i] = pos_r[i] + 1'b1;
                  arr_nxt[i] = 1'b0;
                end else if (!arr_r[i]) begin
                  arr_nxt[i]  = 1'b1;
                  save_vec[i] = 1'b1;
                end
              end
              slew_cnt_nxt = slew_div_r;
            end
          end else begin
            adc_req = (32'(adc_ch_r) < 3) ? 2'(adc_ch_r) : ADC_NONE;
          end
          frame_cnt_nxt = frame_dec;
          if (frame_dec == 8'd0) begin
            // frame fires: moving servos, or all of them
            for (int i = 0; i < NUM_SERVOS; i++) begin
              pulse_vec[i] = !arr_nxt[i] || phase_r != PH_RUN || always_r;
            end
            frame_cnt_nxt = pulse_div_r;
          end
        end
        MODE_BUTTON: begin
          unique case (phase_r)
            PH_RUN:   phase_nxt = PH_START;
            PH_START: phase_nxt = PH_END;
            default: begin
              phase_nxt = PH_RUN;
              save_cal  = 1'b1;
            end
          endcase
        end
        MODE_COMMAND: begin
          for (int i = 0; i < NUM_SERVOS; i++) begin
            if (32'(servo_r) == i) begin
              if (choice_r == CH_OPEN) tgt_nxt[i] = start_r[i];
              else if (choice_r == CH_CLOSE) tgt_nxt[i] = end_r[i];
            end
          end
        end
        MODE_ADC: begin
          for (int i = 0; i < NUM_SERVOS; i++) begin
            if (32'(adc_ch_r) == i) begin
              if (phase_r == PH_START) begin
                start_nxt[i] = sample;
                pos_nxt[i]   = sample;
              end else if (phase_r == PH_END) begin
                end_nxt[i] = sample;
                pos_nxt[i] = sample;
              end
            end
          end
          adc_ch_nxt = (32'(adc_ch_r) == NUM_SERVOS - 1) ? '0 : adc_ch_r + CH_W'(1);
        end
        MODE_RESTORE: begin
          for (int i = 0; i < NUM_SERVOS; i++) begin
            if (32'(servo_r) == i) begin
              if (choice_r == CH_START) begin
                start_nxt[i] = sample;
              end else if (choice_r == CH_END) begin
                end_nxt[i] = sample;
              end else if (choice_r == CH_LAST) begin
                pos_nxt[i] = last_pos;
                tgt_nxt[i] = last_pos;
                arr_nxt[i] = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // LED decode from the phase after this event
  always_comb begin
    unique case (phase_nxt)
      PH_START: led_nxt = LED_GRN;
      PH_END:   led_nxt = LED_RED;
      default:  led_nxt = LED_OFF;
    endcase
  end

  // only the first three servos are brought out
  always_comb begin
    pulse_show = '0;
    save_show  = '0;
    for (int j = 0; j < 3; j++) show_pos[j] = MID_POS;
    for (int j = 0; j < SHOWN; j++) begin
      pulse_show[j] = pulse_vec[j];
      save_show[j]  = save_vec[j];
      show_pos[j]   = pos_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        pos_r[i]   <= MID_POS;
        tgt_r[i]   <= MID_POS;
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
      arr_r       <= '1;
      phase_r     <= PH_RUN;
      slew_cnt_r  <= SLEW_DIV_RST;
      frame_cnt_r <= PULSE_DIV_RST;
      adc_ch_r    <= '0;
    end else begin
      pos_r       <= pos_nxt;
      tgt_r       <= tgt_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      arr_r       <= arr_nxt;
      phase_r     <= phase_nxt;
      slew_cnt_r  <= slew_cnt_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      adc_ch_r    <= adc_ch_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pulse_mask_r <= pulse_show;
      save_mask_r  <= save_show;
      posa_r       <= show_pos[0];
      posb_r       <= show_pos[1];
      posc_r       <= show_pos[2];
      wida_r       <= pulse_width(show_pos[0]);
      widb_r       <= pulse_width(show_pos[1]);
      widc_r       <= pulse_width(show_pos[2]);
      save_cal_r   <= save_cal;
      cal_phase_r  <= phase_nxt;
      led_r        <= led_nxt;
      adc_req_r    <= adc_req;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_pulse_mask         = pulse_mask_r;
  assign out_position_a         = posa_r;
  assign out_position_b         = posb_r;
  assign out_position_c         = posc_r;
  assign out_width_a            = wida_r;
  assign out_width_b            = widb_r;
  assign out_width_c            = widc_r;
  assign out_save_position_mask = save_mask_r;
  assign out_save_calibration   = save_cal_r;
  assign out_cal_phase          = cal_phase_r;
  assign out_led_state          = led_r;
  assign out_adc_request        = adc_req_r;

  // --------------------------------------------------------------------------
  // checks
  a_cal_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && save_cal_r |-> cal_phase_r == PH_RUN)
    else $error("calibration save outside run phase");

  a_save_on_run_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && save_mask_r != 3'd0 |-> cal_phase_r == PH_RUN && adc_req_r == ADC_NONE)
    else $error("arrival flagged outside a run tick");

  a_adc_req_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && adc_req_r != ADC_NONE |-> cal_phase_r != PH_RUN && save_mask_r == 3'd0)
    else $error("adc request outside calibration");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !advance |=> s1_v_r && $stable(mode_r) && $stable(value_r))
    else $error("input stage lost a stalled beat");

  a_led_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cal_phase_r == PH_RUN) == (led_r == LED_OFF))
    else $error("led state disagrees with phase");

endmodule
